>>> hdl/fcpr_pkg.sv
// Shared types, constants and the CRC-8 byte update for the framed command receiver.
// No dependencies.
`timescale 1ns / 1ps

package fcpr_pkg;

  localparam logic [7:0] SYNC_BYTE_RST = 8'hAA;
  localparam int unsigned MAX_PAYLOAD   = 32;
  localparam logic [7:0] MAX_LEN        = 8'(MAX_PAYLOAD);

  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [7:0] ID_ARM    = 8'h01;
  localparam logic [7:0] ID_DISARM = 8'h02;
  localparam logic [7:0] ID_DRIVE  = 8'h03;
  localparam logic [7:0] DRIVE_BYTES = 8'd4;

  // Packed so packet_id lands in the lowest bits.
  typedef struct packed {
    logic               drive_updated;
    logic signed [15:0] right_drive;
    logic signed [15:0] left_drive;
    logic               armed;
    logic [7:0]         packet_id;
  } fcpr_result_t;

  localparam int unsigned RESULT_W = $bits(fcpr_result_t);
  localparam int unsigned TDATA_W  = ((RESULT_W + 7) / 8) * 8;

  // CRC-8, MSB first, no reflection; one byte per call.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/framed_command_packet_receiver.sv
// Top level of the framed command receiver: input byte register, sync-byte register,
// frame parser and result register. Depends on fcpr_pkg, fcpr_core, fcpr_out_reg.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake                    Payload
//  --------  ---  ---------------------------  -------------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] received_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: id, armed, left, right, updated
//  cfg       in   cfg_we_i (no wait)           cfg_wdata_i = frame sync byte
//
// One byte per cycle sustained while the result register is not stalled. A byte is held
// in the input register and parsed by the combinational frame logic; a good frame's result
// is loaded into the result register when the CRC byte leaves the input register.
// Reset clears the phase to hunting, arm flag and drive values to zero, sync byte 0xAA.
// A stalled result register holds the parser; an empty input register still takes one
// more byte, then s_axis_tready drops until the result is taken.

module framed_command_packet_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // received_byte[7:0]
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // packet_id[7:0], armed[8], left_drive[24:9], right_drive[40:25],
  // drive_updated[41], zero fill [47:42]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import fcpr_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic [7:0]   start_q;
  logic         advance;
  logic         out_free;
  logic         res_valid;
  fcpr_result_t res;
  fcpr_result_t out_res;

  // Sync byte; a change mid-frame only matters at the next hunt.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= SYNC_BYTE_RST;
    end else if (cfg_we_i) begin
      start_q <= cfg_wdata_i;
    end
  end

  // Parser steps whenever a byte is held and the result slot can take its outcome.
  assign advance       = in_valid_q & out_free;
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata;
  end

  fcpr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (in_byte_q),
    .sync_byte_i  (start_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  fcpr_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {(TDATA_W - RESULT_W)'(0), out_res};

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("held input byte lost");

endmodule

>>> hdl/fcpr_core.sv
// Frame parser: phase register, running CRC, first payload bytes, arm/drive state.
// Depends on fcpr_pkg.
`timescale 1ns / 1ps

module fcpr_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic [7:0]            sync_byte_i,
  output logic                  res_valid_o,
  output fcpr_pkg::fcpr_result_t res_o
);
  import fcpr_pkg::*;

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_ID      = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;

  logic [2:0]         phase_q, phase_d;
  logic [7:0]         id_q, id_d;
  logic [7:0]         len_q, len_d;
  logic [7:0]         idx_q, idx_d;
  logic [7:0]         crc_q, crc_d;
  logic               armed_q, armed_d;
  logic signed [15:0] left_q, left_d;
  logic signed [15:0] right_q, right_d;
  logic [7:0]         pay_q [4];
  logic               pay_we;
  logic               upd;
  logic               valid;

  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    len_d   = len_q;
    idx_d   = idx_q;
    crc_d   = crc_q;
    armed_d = armed_q;
    left_d  = left_q;
    right_d = right_q;
    pay_we  = 1'b0;
    upd     = 1'b0;
    valid   = 1'b0;
    case (phase_q)
      PH_START: begin
        if (byte_i == sync_byte_i) phase_d = PH_ID;
      end
      PH_ID: begin
        id_d    = byte_i;
        crc_d   = crc8_feed(8'h00, byte_i);
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d = byte_i;
        crc_d = crc8_feed(crc_q, byte_i);
        idx_d = 8'd0;
        if (byte_i > MAX_LEN) begin
          phase_d = PH_START;
        end else if (byte_i == 8'd0) begin
          phase_d = PH_CRC;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pay_we = (idx_q < DRIVE_BYTES);
        crc_d  = crc8_feed(crc_q, byte_i);
        idx_d  = idx_q + 8'd1;
        if (idx_d >= len_q) phase_d = PH_CRC;
      end
      PH_CRC: begin
        phase_d = PH_START;
        if (byte_i == crc_q) begin
          valid = 1'b1;
          if (id_q == ID_ARM) begin
            armed_d = 1'b1;
          end else if (id_q == ID_DISARM) begin
            armed_d = 1'b0;
          end else if (id_q == ID_DRIVE && len_q == DRIVE_BYTES) begin
            left_d  = {pay_q[1], pay_q[0]};
            right_d = {pay_q[3], pay_q[2]};
            upd     = 1'b1;
          end
        end
      end
      default: phase_d = PH_START;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      id_q    <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      crc_q   <= '0;
      armed_q <= 1'b0;
      left_q  <= '0;
      right_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      crc_q   <= crc_d;
      armed_q <= armed_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  // First four payload bytes; no reset, read only after a full drive frame.
  always_ff @(posedge clk_i) begin
    if (step_i && pay_we) pay_q[idx_q[1:0]] <= byte_i;
  end

  assign res_valid_o         = step_i & valid;
  assign res_o.packet_id     = id_q;
  assign res_o.armed         = armed_d;
  assign res_o.left_drive    = left_d;
  assign res_o.right_drive   = right_d;
  assign res_o.drive_updated = upd;

  a_res_from_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> phase_q == PH_CRC && byte_i == crc_q)
    else $error("result outside CRC phase");

  a_upd_is_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.drive_updated |-> id_q == ID_DRIVE && len_q == DRIVE_BYTES)
    else $error("drive update from wrong frame");

  a_long_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_LEN && byte_i > MAX_LEN |=> phase_q == PH_START)
    else $error("oversize length not dropped");

endmodule

>>> hdl/fcpr_out_reg.sv
// Result register on the master side; holds a result until it is taken.
// Depends on fcpr_pkg.
`timescale 1ns / 1ps

module fcpr_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  fcpr_pkg::fcpr_result_t res_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output fcpr_pkg::fcpr_result_t res_o
);
  import fcpr_pkg::*;

  logic         valid_q;
  fcpr_result_t res_q;

  assign free_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
